FILE: design/etse_pkg.sv
`default_nettype none
package etse_pkg;
   localparam int SLOTS_DEF = 8;
   localparam int TARGET_ID_BITS_DEF = 8;
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_BUSY  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;
   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_VALUE = 3'd1;
   localparam logic [2:0] KIND_BUSY  = 3'd2;
   localparam logic [2:0] KIND_CLEAR = 3'd3;
   localparam logic [2:0] KIND_IDLE  = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  target_id;
      logic [15:0] start_value;
      logic [15:0] end_value;
      logic [7:0]  frame_count;
      logic [1:0]  ease_curve;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [7:0]  out_target;
      logic [15:0] out_value;
      logic        flag;
      logic        finished;
      logic        last;
   } rsp_type;

   function automatic logic [8:0] curve_point(input logic [1:0] c, input logic [4:0] k);
      logic [8:0] r;
      r = 9'd0;
      case (c)
         2'd0: r = {k, 4'd0};
         2'd1: r = 9'(k * k);
         2'd2: begin
            case (k)
               5'd0: r = 9'd0;   5'd1: r = 9'd31;  5'd2: r = 9'd60;  5'd3: r = 9'd87;
               5'd4: r = 9'd112; 5'd5: r = 9'd135; 5'd6: r = 9'd156; 5'd7: r = 9'd175;
               5'd8: r = 9'd192; 5'd9: r = 9'd207; 5'd10: r = 9'd220; 5'd11: r = 9'd231;
               5'd12: r = 9'd240; 5'd13: r = 9'd247; 5'd14: r = 9'd252; 5'd15: r = 9'd255;
               default: r = 9'd256;
            endcase
         end
         default: begin
            case (k)
               5'd0: r = 9'd0;   5'd1: r = 9'd2;   5'd2: r = 9'd8;   5'd3: r = 9'd18;
               5'd4: r = 9'd32;  5'd5: r = 9'd50;  5'd6: r = 9'd72;  5'd7: r = 9'd98;
               5'd8: r = 9'd128; 5'd9: r = 9'd158; 5'd10: r = 9'd184; 5'd11: r = 9'd206;
               5'd12: r = 9'd224; 5'd13: r = 9'd238; 5'd14: r = 9'd248; 5'd15: r = 9'd254;
               default: r = 9'd256;
            endcase
         end
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: design/etse_if.sv
`default_nettype none
interface etse_req_if;
   logic valid;
   logic ready;
   etse_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface etse_rsp_if;
   logic valid;
   logic ready;
   etse_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/etse_front.sv
`default_nettype none
module etse_front #(
   parameter int TARGET_ID_BITS = etse_pkg::TARGET_ID_BITS_DEF
) (
   etse_req_if.sink               req,
   input  wire logic              q_full,
   output etse_pkg::req_type      q_data,
   output logic                   q_push
);
   // mask target id and force duration nonzero before queueing
   assign req.ready = !q_full;
   assign q_push = req.valid && !q_full;
   always_comb begin
      q_data = req.payload;
      q_data.target_id = 8'(req.payload.target_id & 8'((16'd1 << TARGET_ID_BITS) - 16'd1));
      if (req.payload.frame_count == 8'd0) q_data.frame_count = 8'd1;
   end
endmodule
`default_nettype wire

FILE: design/etse_queue.sv
`default_nettype none
module etse_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  etse_pkg::req_type  push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output etse_pkg::req_type  head
);
   etse_pkg::req_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

FILE: design/etse_back.sv
`default_nettype none
module etse_back #(
   parameter int SLOTS = etse_pkg::SLOTS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  etse_pkg::req_type  q_head,
   output logic               q_pop,
   etse_rsp_if.source         rsp
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_MUL, S_EMIT, S_OUT} state_type;

   state_type state_ff;
   logic [SLOTS-1:0] active_ff;
   logic [7:0]  tgt_ff  [SLOTS];
   logic [15:0] from_ff [SLOTS];
   logic [15:0] to_ff   [SLOTS];
   logic [7:0]  el_ff   [SLOTS];
   logic [7:0]  dur_ff  [SLOTS];
   logic [1:0]  cur_ff  [SLOTS];

   logic [CW-1:0] idx_ff;
   logic        any_ff;
   logic [15:0] rem_ff;
   logic [8:0]  quo_ff;
   logic [3:0]  bit_ff;
   logic [8:0]  e_ff;
   logic signed [26:0] prod_ff;
   logic        outv_ff;
   etse_pkg::rsp_type out_ff;

   // combinational lookups
   logic hit, has_free;
   logic [SW-1:0] hit_idx, free_idx, pick;
   always_comb begin
      hit = 1'b0; has_free = 1'b0; hit_idx = '0; free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (active_ff[i] && tgt_ff[i] == q_head.target_id) begin
            hit = 1'b1; hit_idx = SW'(i);
         end
         if (!active_ff[i]) begin
            has_free = 1'b1; free_idx = SW'(i);
         end
      end
      pick = hit ? hit_idx : free_idx;
   end

   logic [SW-1:0] cur;
   assign cur = idx_ff[SW-1:0];
   logic [7:0] el_next;
   assign el_next = el_ff[cur] + 8'd1;

   logic [16:0] trial;
   assign trial = {rem_ff, 1'b0} - {9'd0, dur_ff[cur]};

   logic [8:0] ya, yb, ediff, e_calc;
   assign ya = etse_pkg::curve_point(cur_ff[cur], {1'b0, quo_ff[7:4]});
   assign yb = etse_pkg::curve_point(cur_ff[cur], 5'({1'b0, quo_ff[7:4]} + 5'd1));
   assign ediff = yb - ya;
   assign e_calc = quo_ff[8] ? 9'd256 : 9'(ya + 9'(({4'd0, ediff} * {9'd0, quo_ff[3:0]}) >> 4));

   logic signed [16:0] diff;
   assign diff = 17'($signed(to_ff[cur])) - 17'($signed(from_ff[cur]));
   logic signed [26:0] q_sh;
   assign q_sh = prod_ff >>> 8;

   assign rsp.valid = outv_ff;
   assign rsp.payload = out_ff;
   logic out_free;
   assign out_free = !outv_ff || rsp.ready;

   always_ff @(posedge clock) begin
      q_pop <= 1'b0;
      if (rsp.ready) outv_ff <= 1'b0;
      unique case (state_ff)
         S_IDLE: if (q_valid && !q_pop && out_free) begin
            q_pop <= 1'b1;
            outv_ff <= 1'b1;
            out_ff <= '0;
            out_ff.last <= 1'b1;
            out_ff.out_target <= q_head.target_id;
            unique case (q_head.operation)
               etse_pkg::OP_START: begin
                  out_ff.result_kind <= etse_pkg::KIND_START;
                  out_ff.flag <= hit || has_free;
                  if (hit || has_free) begin
                     active_ff[pick] <= 1'b1;
                     tgt_ff[pick] <= q_head.target_id;
                     from_ff[pick] <= q_head.start_value;
                     to_ff[pick] <= q_head.end_value;
                     el_ff[pick] <= 8'd0;
                     dur_ff[pick] <= q_head.frame_count;
                     cur_ff[pick] <= q_head.ease_curve;
                  end
               end
               etse_pkg::OP_BUSY: begin
                  out_ff.result_kind <= etse_pkg::KIND_BUSY;
                  out_ff.flag <= hit;
               end
               etse_pkg::OP_CLEAR: begin
                  out_ff.result_kind <= etse_pkg::KIND_CLEAR;
                  out_ff.out_target <= 8'd0;
                  active_ff <= '0;
               end
               default: begin
                  outv_ff <= 1'b0;
                  idx_ff <= '0;
                  any_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            if (idx_ff == CW'(SLOTS)) begin
               if (!any_ff) state_ff <= S_OUT;
               else state_ff <= S_IDLE;
            end else if (!active_ff[cur]) begin
               idx_ff <= idx_ff + CW'(1);
            end else begin
               el_ff[cur] <= el_next;
               rem_ff <= {8'd0, el_next};
               quo_ff <= '0;
               bit_ff <= 4'd8;
               state_ff <= S_DIV;
            end
         end
         S_DIV: begin
            // restoring division of elapsed*256 by duration, one bit a cycle
            if (bit_ff == 4'd0) begin
               // register the interpolated curve point ahead of the multiply
               e_ff <= e_calc;
               state_ff <= S_MUL;
            end else begin
               bit_ff <= bit_ff - 4'd1;
               if (!trial[16]) begin
                  rem_ff <= trial[15:0]; quo_ff <= {quo_ff[7:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[14:0], 1'b0}; quo_ff <= {quo_ff[7:0], 1'b0};
               end
            end
         end
         S_MUL: begin
            prod_ff <= 27'(diff * $signed({1'b0, e_ff}));
            state_ff <= S_EMIT;
         end
         S_EMIT: if (out_free) begin
            any_ff <= 1'b1;
            outv_ff <= 1'b1;
            out_ff <= '0;
            out_ff.result_kind <= etse_pkg::KIND_VALUE;
            out_ff.out_target <= tgt_ff[cur];
            if (el_ff[cur] >= dur_ff[cur]) begin
               active_ff[cur] <= 1'b0;
               out_ff.finished <= 1'b1;
               out_ff.out_value <= to_ff[cur];
            end else begin
               out_ff.out_value <= 16'(from_ff[cur] + q_sh[15:0]);
            end
            out_ff.last <= (((active_ff >> cur) >> 1) == '0);
            idx_ff <= idx_ff + CW'(1);
            state_ff <= S_SCAN;
         end
         default: if (out_free) begin
            outv_ff <= 1'b1;
            out_ff <= '0;
            out_ff.result_kind <= etse_pkg::KIND_IDLE;
            out_ff.last <= 1'b1;
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= '0;
         outv_ff <= 1'b0;
         q_pop <= 1'b0;
      end
   end
endmodule
`default_nettype wire

FILE: design/eased_tween_slot_engine.sv
`default_nettype none
// Start, busy and clear: the request passes through the queue, and the back end
// registers its result; it pops no new request while its last pop is pending.
// Tick: the scan skips free slots; an active slot takes an 8-step serial divider,
// interpolate, multiply and emit; the scan ends with an idle answer if none was active.
// Sequential; the back end takes one queued transaction at a time.
// Synchronous active-high reset frees all slots and empties the queue.
module eased_tween_slot_engine #(
   parameter int SLOTS = etse_pkg::SLOTS_DEF,
   parameter int TARGET_ID_BITS = etse_pkg::TARGET_ID_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   etse_req_if.sink   req,
   etse_rsp_if.source rsp
);
   etse_pkg::req_type push_data, head;
   logic full, push, pop, not_empty;

   etse_front #(.TARGET_ID_BITS(TARGET_ID_BITS)) u_front (
      .req(req), .q_full(full), .q_data(push_data), .q_push(push));
   etse_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .full(full), .pop(pop), .not_empty(not_empty), .head(head));
   etse_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset), .q_valid(not_empty), .q_head(head),
      .q_pop(pop), .rsp(rsp));
endmodule
`default_nettype wire

FILE: design/etse_checker.sv
`default_nettype none
module etse_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input etse_pkg::rsp_type rsp_payload
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped while stalled");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.finished |-> rsp_payload.result_kind == etse_pkg::KIND_VALUE)
      else $error("finished outside value write");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind != etse_pkg::KIND_VALUE |-> rsp_payload.last)
      else $error("single answer without last");
   a_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind != etse_pkg::KIND_VALUE |->
      rsp_payload.out_value == 16'd0)
      else $error("value outside value write");
endmodule

bind eased_tween_slot_engine etse_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));
`default_nettype wire
